@@ sv/ump_ddf_pkg.sv @@
// ----------------------------------------------------------------------------
// ump_ddf_pkg
// Shared types and constants of the UMP deframer with duplicate filter.
// ----------------------------------------------------------------------------
package ump_ddf_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned SeqW     = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned MsgLenW  = 3;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned MsgWords = 4;
  localparam int unsigned PartW    = 3;
  localparam int unsigned OutRawW  = MsgWords * WordW + MsgLenW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;

  localparam logic [SeqW-1:0] SeqResetVal = 16'hFFFF;

  typedef logic [WordW-1:0] word_t;
  typedef logic [SeqW-1:0]  seq_t;

  // message length by UMP type nibble
  function automatic logic [MsgLenW-1:0] msg_len_by_type(input logic [3:0] mt);
    logic [MsgLenW-1:0] len;
    case (mt)
      4'h0, 4'h1, 4'h2, 4'h6, 4'h7: len = 3'd1;
      4'h3, 4'h4, 4'h8, 4'h9, 4'hA: len = 3'd2;
      4'hB, 4'hC:                   len = 3'd3;
      default:                      len = 3'd4;
    endcase
    return len;
  endfunction

endpackage

@@ sv/ump_deframer_with_duplicate_filter_unit.sv @@
// ----------------------------------------------------------------------------
// ump_deframer_with_duplicate_filter_unit
// Splits UMP data commands into messages and drops repeated packets.
// ----------------------------------------------------------------------------
// Input and result registers; between them the history compare is a
//   parallel match over HISTORY_DEPTH entries. Throughput: one word per
//   cycle unless the master side stalls.
// Reset: asynchronous, active low; history fills with 0xFFFF, no packet open.
module ump_deframer_with_duplicate_filter_unit #(
  parameter int unsigned HISTORY_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [ump_ddf_pkg::WordW-1:0]       s_axis_tdata_i,  // [31:0] word
  input  logic                                s_axis_tuser_i,  // [0] is_header
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] msg_word0, [63:32] msg_word1, [95:64] msg_word2,
  // [127:96] msg_word3, [130:128] msg_length, rest zero
  output logic [ump_ddf_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import ump_ddf_pkg::*;

  logic                in_valid_q, in_valid_d;
  word_t               in_word_q;
  logic                in_hdr_q;
  logic                adv;

  seq_t                hist_q [HISTORY_DEPTH];
  logic [CountW-1:0]   words_left_q;
  logic                drop_q;
  word_t               part_q [PartW];
  logic [IdxW-1:0]     idx_q;
  logic [MsgLenW-1:0]  exp_len_q;

  logic                out_valid_q;
  word_t               out_w_q [MsgWords];
  logic [MsgLenW-1:0]  out_len_q;

  logic                hit;
  logic [MsgLenW-1:0]  cur_len;
  logic                done;
  logic                busy;
  logic [CountW-1:0]   wl_dec;
  word_t               msg [MsgWords];

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || adv;
  assign in_valid_d      = (s_axis_tvalid_i && s_axis_tready_o) ? 1'b1 :
                           (adv ? 1'b0 : in_valid_q);

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist_q[i] == in_word_q[SeqW-1:0]) hit = 1'b1;
    end
  end

  assign busy    = !in_hdr_q && (words_left_q != '0) && !drop_q;
  assign wl_dec  = words_left_q - 1'b1;
  assign cur_len = (idx_q == '0) ? msg_len_by_type(in_word_q[WordW-1 -: 4]) : exp_len_q;
  assign done    = ({1'b0, idx_q} + 3'd1) >= cur_len;

  always_comb begin
    for (int i = 0; i < MsgWords; i++) begin
      if (i == int'(idx_q)) begin
        msg[i] = in_word_q;
      end else if (i < int'(idx_q)) begin
        msg[i] = part_q[i];
      end else begin
        msg[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_word_q <= s_axis_tdata_i;
      in_hdr_q  <= s_axis_tuser_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= SeqResetVal;
      for (int i = 0; i < PartW; i++) part_q[i] <= '0;
      words_left_q <= '0;
      drop_q       <= 1'b0;
      idx_q        <= '0;
      exp_len_q    <= '0;
      out_valid_q  <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q && busy && done;
      if (in_valid_q) begin
        if (in_hdr_q) begin
          words_left_q <= in_word_q[23:16];
          idx_q        <= '0;
          exp_len_q    <= '0;
          drop_q       <= hit;
          if (!hit) begin
            for (int i = 0; i + 1 < HISTORY_DEPTH; i++) hist_q[i] <= hist_q[i+1];
            hist_q[HISTORY_DEPTH-1] <= in_word_q[SeqW-1:0];
          end
        end else if (words_left_q != '0) begin
          words_left_q <= wl_dec;
          if (!drop_q) begin
            exp_len_q <= cur_len;
            if (done) begin
              idx_q <= '0;
            end else begin
              part_q[idx_q] <= in_word_q;
              idx_q         <= (wl_dec == '0) ? '0 : idx_q + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q && busy && done) begin
      for (int i = 0; i < MsgWords; i++) out_w_q[i] <= msg[i];
      out_len_q <= cur_len;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({out_len_q, out_w_q[3], out_w_q[2], out_w_q[1], out_w_q[0]});

endmodule

@@ sv/ump_ddf_checker.sv @@
// ----------------------------------------------------------------------------
// ump_ddf_checker
// Port-level checks of the UMP deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ump_ddf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [135:0] m_axis_tdata_o
);

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[130:128] != 3'd0) && (m_axis_tdata_o[130:128] <= 3'd4))
    else $error("message length out of range");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tdata_o[130:128] >= 3'd4) || (m_axis_tdata_o[127:96] == '0)) &&
      ((m_axis_tdata_o[130:128] >= 3'd3) || (m_axis_tdata_o[95:64] == '0)) &&
      ((m_axis_tdata_o[130:128] >= 3'd2) || (m_axis_tdata_o[63:32] == '0)))
    else $error("unused message word not zero");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("message without preceding transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled message changed");

endmodule

bind ump_deframer_with_duplicate_filter_unit ump_ddf_checker u_ump_ddf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ tb/sv/ump_deframer_with_duplicate_filter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ump_deframer_with_duplicate_filter_unit_tb
// Self-checking bench for the UMP deframer with duplicate filter. A short
// directed table hits repeated packet numbers, zero-length payloads, cut-short
// messages, headers inside a packet and stray words. Random packets follow,
// mostly well-formed with random message types, some truncated or repeated.
// Messages of predicted rows come from an internal deframer model, the rest
// from the table. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module ump_deframer_with_duplicate_filter_unit_tb;
  import ump_ddf_pkg::*;

  localparam int unsigned HistDepth  = 4;
  localparam int unsigned MsgBits    = MsgWords * WordW + MsgLenW;
  localparam int unsigned DirCount   = 25;
  localparam int unsigned RandItems  = 1350;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainLimit = 5000;
  localparam int unsigned TailCycles = 20;

  // message length by type nibble, entry 0 in the low bits
  localparam logic [47:0] MsgLenTbl = {3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2,
                                       3'd1, 3'd1, 3'd4, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1};

  typedef struct packed {
    logic [MsgLenW-1:0] len;
    word_t              w3;
    word_t              w2;
    word_t              w1;
    word_t              w0;
  } ump_msg_t;

  typedef enum logic [1:0] {RowPredicted, RowNoMsg, RowMsg} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic      hdr;
    word_t     word;
    ump_msg_t  msg;
  } stim_row_t;

  localparam ump_msg_t NoMsg   = '0;
  localparam ump_msg_t MsgZero = {3'd1, 32'h0, 32'h0, 32'h0, 32'h0};
  localparam ump_msg_t MsgOnes = {3'd4, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                  32'hFFFFFFFF};

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  word_t               s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int unsigned snk_idle    = 46;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;

  stim_row_t stim_q[$];
  ump_msg_t  pending_msgs[$];

  // deframer model state
  seq_t        seq_hist [HistDepth];
  logic [7:0]  words_left;
  logic        drop_pkt;
  word_t       part_words [3];
  logic [1:0]  word_idx;
  logic [2:0]  cur_len;

  stim_row_t directed_rows [DirCount] = '{
    '{RowNoMsg,     1'b1, 32'h2001FFFF, NoMsg},   // number equals reset value
    '{RowNoMsg,     1'b0, 32'h20000000, NoMsg},
    '{RowNoMsg,     1'b1, 32'h20010000, NoMsg},
    '{RowMsg,       1'b0, 32'h00000000, MsgZero},
    '{RowNoMsg,     1'b0, 32'h12345678, NoMsg},   // outside a packet
    '{RowNoMsg,     1'b1, 32'hFF040001, NoMsg},
    '{RowNoMsg,     1'b0, 32'hFFFFFFFF, NoMsg},
    '{RowNoMsg,     1'b0, 32'hFFFFFFFF, NoMsg},
    '{RowNoMsg,     1'b0, 32'hFFFFFFFF, NoMsg},
    '{RowMsg,       1'b0, 32'hFFFFFFFF, MsgOnes},
    '{RowNoMsg,     1'b1, 32'h20000002, NoMsg},   // zero-length payload
    '{RowNoMsg,     1'b0, 32'h11111111, NoMsg},
    '{RowNoMsg,     1'b1, 32'h20020002, NoMsg},   // repeated number
    '{RowNoMsg,     1'b0, 32'h40000000, NoMsg},
    '{RowNoMsg,     1'b0, 32'h00000000, NoMsg},
    '{RowPredicted, 1'b1, 32'h20020003, NoMsg},
    '{RowPredicted, 1'b0, 32'hD0000001, NoMsg},
    '{RowPredicted, 1'b0, 32'h00000002, NoMsg},   // cut short
    '{RowPredicted, 1'b1, 32'h00FF0004, NoMsg},
    '{RowPredicted, 1'b0, 32'h30000010, NoMsg},
    '{RowPredicted, 1'b1, 32'h20020005, NoMsg},   // header inside a packet
    '{RowPredicted, 1'b0, 32'h80000020, NoMsg},
    '{RowPredicted, 1'b0, 32'h00000021, NoMsg},
    '{RowPredicted, 1'b1, 32'h2001FFFF, NoMsg},
    '{RowPredicted, 1'b0, 32'h60000000, NoMsg}
  };

  ump_deframer_with_duplicate_filter_unit #(
    .HISTORY_DEPTH(HistDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  function automatic void deframer_reset();
    for (int i = 0; i < HistDepth; i++) seq_hist[i] = SeqResetVal;
    words_left = '0;
    drop_pkt   = 1'b0;
    for (int i = 0; i < 3; i++) part_words[i] = '0;
    word_idx   = '0;
    cur_len    = '0;
  endfunction

  function automatic bit deframe_word(input word_t w, input logic hdr, output ump_msg_t msg);
    bit    hit;
    seq_t  num;
    word_t words [4];
    msg = '0;
    if (hdr) begin
      num        = w[15:0];
      words_left = w[23:16];
      word_idx   = '0;
      cur_len    = '0;
      hit        = 1'b0;
      for (int i = 0; i < HistDepth; i++) if (seq_hist[i] == num) hit = 1'b1;
      drop_pkt = hit;
      if (!hit) begin
        for (int i = 0; i + 1 < HistDepth; i++) seq_hist[i] = seq_hist[i + 1];
        seq_hist[HistDepth - 1] = num;
      end
      return 1'b0;
    end
    if (words_left == 0) return 1'b0;
    words_left = words_left - 8'd1;
    if (drop_pkt) return 1'b0;
    if (word_idx == 0) cur_len = MsgLenTbl[int'(w[31:28]) * 3 +: 3];
    if ({1'b0, word_idx} + 3'd1 >= cur_len) begin
      for (int i = 0; i < 4; i++) words[i] = (i < word_idx) ? part_words[i] : '0;
      words[word_idx] = w;
      msg = {cur_len, words[3], words[2], words[1], words[0]};
      word_idx = '0;
      return 1'b1;
    end
    part_words[word_idx] = w;
    word_idx = word_idx + 2'd1;
    if (words_left == 0) word_idx = '0;
    return 1'b0;
  endfunction

  function automatic void push_word(input word_t w, input logic hdr);
    stim_q.push_back('{RowPredicted, hdr, w, NoMsg});
  endfunction

  task automatic gen_random_packets();
    int unsigned n_items;
    int unsigned r;
    int unsigned len;
    int unsigned left;
    int unsigned mt;
    int unsigned ml;
    int unsigned k;
    seq_t        num;
    seq_t        recent[$];
    word_t       w;
    n_items = 0;
    while (n_items < RandItems) begin
      if ($urandom_range(0, 99) < 8) push_word($urandom, 1'b0);
      r = $urandom_range(0, 199);
      if (r < 3) len = $urandom_range(33, 255);
      else if (r < 27) len = $urandom_range(11, 32);
      else len = $urandom_range(0, 10);
      if (recent.size() > 0 && $urandom_range(0, 99) < 25)
        num = recent[$urandom_range(0, recent.size() - 1)];
      else if ($urandom_range(0, 99) < 2) num = SeqResetVal;
      else num = 16'($urandom);
      recent.push_back(num);
      if (recent.size() > 6) void'(recent.pop_front());
      push_word({8'($urandom), 8'(len), num}, 1'b1);
      n_items++;
      left = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len) : len;
      while (left > 0) begin
        mt = $urandom_range(0, 15);
        if (MsgLenTbl[mt * 3 +: 3] > left && $urandom_range(0, 3) != 0) begin
          k  = $urandom_range(0, 4);
          mt = (k < 3) ? k : k + 3;
        end
        ml = MsgLenTbl[mt * 3 +: 3];
        for (int j = 0; j < ml && left > 0; j++) begin
          w = $urandom;
          if (j == 0) w[31:28] = mt[3:0];
          push_word(w, 1'b0);
          left--;
          n_items++;
        end
      end
    end
  endtask

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= snk_idle);
  end

  always @(posedge clk_i) begin : msg_monitor
    ump_msg_t got;
    ump_msg_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[MsgBits-1:0];
      if (pending_msgs.size() == 0) begin
        report_mismatch("message with none pending, msg_word0", got.w0, '0);
      end else begin
        want = pending_msgs.pop_front();
        if (got.w0 !== want.w0) report_mismatch("msg_word0", got.w0, want.w0);
        if (got.w1 !== want.w1) report_mismatch("msg_word1", got.w1, want.w1);
        if (got.w2 !== want.w2) report_mismatch("msg_word2", got.w2, want.w2);
        if (got.w3 !== want.w3) report_mismatch("msg_word3", got.w3, want.w3);
        if (got.len !== want.len) report_mismatch("msg_length", 32'(got.len), 32'(want.len));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ump_deframer_with_duplicate_filter_unit verification failed");
      $finish;
    end
  end

  initial begin : stim_driver
    int unsigned total;
    int unsigned src_idle;
    int unsigned wait_cycles;
    stim_row_t   row;
    ump_msg_t    msg;
    bit          has_msg;
    deframer_reset();
    for (int i = 0; i < DirCount; i++) stim_q.push_back(directed_rows[i]);
    gen_random_packets();
    total = stim_q.size();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < total; i++) begin
      row = stim_q[i];
      if (i < total / 3) begin
        src_idle = 37;
        snk_idle = 46;
      end else if (i < 2 * total / 3) begin
        src_idle = 46;
        snk_idle = 37;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      while ($urandom_range(0, 99) < src_idle) begin
        s_tvalid <= 1'b0;
        @(negedge clk_i);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= row.word;
      s_tuser  <= row.hdr;
      @(posedge clk_i);
      while (!s_tready) @(posedge clk_i);
      has_msg = deframe_word(row.word, row.hdr, msg);
      case (row.kind)
        RowPredicted: if (has_msg) pending_msgs.push_back(msg);
        RowMsg:       pending_msgs.push_back(row.msg);
        default:      ;
      endcase
      @(negedge clk_i);
    end
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_msgs.size() != 0 && wait_cycles < DrainLimit) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (pending_msgs.size() != 0)
      report_mismatch("messages left pending, count", 32'(pending_msgs.size()), '0);
    if (err_count == 0) begin
      $display("ump_deframer_with_duplicate_filter_unit verification clean");
    end else begin
      $display("ump_deframer_with_duplicate_filter_unit verification failed");
    end
    $finish;
  end

endmodule
